// ===== design/assert_macros.svh =====
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CHK_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");

// same cycle implication
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same cycle implication violated");

// next cycle implication
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next cycle implication violated");

`endif

// ===== design/utfs_pkg.sv =====
package utfs_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEVEL_W    = 4;
  localparam int BITS_W     = 4;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 4'd15;
  // eight data bits plus the stop bit
  localparam logic [BITS_W-1:0]  FRAME_BITS = 4'd9;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_PUSH = 1'b1
  } action_t;

  // requests from the serializer to the fifo
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [BYTE_W-1:0] wr_data;
  } fifo_ctrl_t;

  // fifo status seen by the serializer
  typedef struct packed {
    logic               full;
    logic               empty;
    logic [BYTE_W-1:0]  head;
    logic [LEVEL_W-1:0] level_nxt;
  } fifo_stat_t;

endpackage

// ===== design/uart_tx_fifo_serializer.sv =====
// uart transmitter 8n1, lsb first, fed from a byte ring fifo. each input word is
// either a bit-period tick (in_tuser = 0) or a push of in_tdata into the fifo
// (in_tuser = 1), and each word yields exactly one registered result word:
// the line level after the step, whether a push was stored, and the fill level
// (saturating at 15). the ring keeps one slot free, so it holds FIFO_DEPTH-1
// bytes; a push to a full ring is dropped and reported with push_accepted = 0.
// a tick while idle with a byte waiting sends the start bit, the next eight
// ticks send the data bits and the ninth the stop bit; with nothing waiting the
// line holds. cfg_wr_data = 1 inverts the line (idle low) and should be written
// while no word is in flight. one word per clock is taken whenever the result
// register is empty or being drained; the only stall is out_tready low.
`include "assert_macros.svh"

module uart_tx_fifo_serializer #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  // input words
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_value
  input  logic [0:0] in_tuser,   // [0] action: 0 tick, 1 push
  // result words
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] tx_line, [1] push_accepted, [5:2] fifo_level, [7:6] zero
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data // invert_line
);
  import utfs_pkg::*;

  logic              in_fire;
  action_t           act;
  fifo_ctrl_t        ctrl;
  fifo_stat_t        stat;

  // serializer state
  logic [BITS_W-1:0] bits_r, bits_nxt;
  logic [BYTE_W-1:0] shift_r, shift_nxt;
  logic              line_r, line_nxt;   // logical level, 1 = mark
  logic              inv_r;

  // result register
  logic              out_vld_r;
  logic [7:0]        out_data_r;
  logic              push_ok;

  assign in_tready = !out_vld_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign act       = action_t'(in_tuser[0]);

  // bytes are stored complemented so zeros shifted in give the stop level
  assign push_ok      = in_fire && (act == ACT_PUSH) && !stat.full;
  assign ctrl.push    = push_ok;
  assign ctrl.pop     = in_fire && (act == ACT_TICK) && (bits_r == '0) && !stat.empty;
  assign ctrl.wr_data = ~in_tdata;

  utfs_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .stat  (stat)
  );

  always_comb begin
    bits_nxt  = bits_r;
    shift_nxt = shift_r;
    line_nxt  = line_r;
    if (in_fire && (act == ACT_TICK)) begin
      if (bits_r != '0) begin
        // a set bit of the complemented byte is a data zero
        bits_nxt  = bits_r - 1'b1;
        line_nxt  = ~shift_r[0];
        shift_nxt = {1'b0, shift_r[BYTE_W-1:1]};
      end else if (!stat.empty) begin
        // start bit
        bits_nxt  = FRAME_BITS;
        shift_nxt = stat.head;
        line_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r  <= '0;
      shift_r <= '0;
      line_r  <= 1'b1;
      inv_r   <= 1'b0;
    end else begin
      bits_r  <= bits_nxt;
      shift_r <= shift_nxt;
      line_r  <= line_nxt;
      if (cfg_wr_en) begin
        inv_r <= cfg_wr_data;
      end
    end
  end

  // result register, reloaded on every accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {2'b00, stat.level_nxt, push_ok, line_nxt ^ inv_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  `CHK_ALWAYS(a_bits_range, bits_r <= FRAME_BITS)
  `CHK_NEXT(a_full_drop, in_fire && (act == ACT_PUSH) && stat.full, !out_data_r[1])
  `CHK_NEXT(a_idle_hold, in_fire && (act == ACT_TICK) && (bits_r == '0) && stat.empty,
            $stable(line_r))

endmodule

// ===== design/utfs_fifo.sv =====
`include "assert_macros.svh"

module utfs_fifo #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  utfs_pkg::fifo_ctrl_t ctrl,
  output utfs_pkg::fifo_stat_t stat
);
  import utfs_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int DIF_W = PTR_W + 1;
  localparam int CMP_W = (DIF_W > LEVEL_W) ? DIF_W : LEVEL_W;

  logic [BYTE_W-1:0] mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wp_r, wp_nxt, wp_inc;
  logic [PTR_W-1:0]  rp_r, rp_nxt, rp_inc;
  logic [BYTE_W-1:0] head_r;
  logic [DIF_W-1:0]  diff;
  logic [CMP_W-1:0]  diff_w;

  // ring pointers wrap at the depth, which need not be a power of two
  assign wp_inc = (wp_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_inc = (rp_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign wp_nxt = ctrl.push ? wp_inc : wp_r;
  assign rp_nxt = ctrl.pop  ? rp_inc : rp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wp_r] <= ctrl.wr_data;
    end
  end

  // registered read of the next head, with bypass of a write to that slot
  always_ff @(posedge clk) begin
    if (ctrl.push && (wp_r == rp_nxt)) begin
      head_r <= ctrl.wr_data;
    end else begin
      head_r <= mem[rp_nxt];
    end
  end

  always_comb begin
    if (wp_nxt >= rp_nxt) begin
      diff = {1'b0, wp_nxt} - {1'b0, rp_nxt};
    end else begin
      diff = DIF_W'(FIFO_DEPTH) - {1'b0, rp_nxt} + {1'b0, wp_nxt};
    end
    diff_w = CMP_W'(diff);
  end

  assign stat.full      = (wp_inc == rp_r);
  assign stat.empty     = (wp_r == rp_r);
  assign stat.head      = head_r;
  assign stat.level_nxt = (diff_w > CMP_W'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(diff_w);

  `CHK_SAME(a_push_not_full, ctrl.push, !stat.full)
  `CHK_SAME(a_pop_not_empty, ctrl.pop, !stat.empty && !ctrl.push)
  `CHK_NEXT(a_push_fills, ctrl.push, !stat.empty)

endmodule
